// ----- design/pfm_pkg.sv -----
// Shared widths, register codes and types for the pulse flow meter.
`timescale 1ns / 1ps
`default_nettype none

package pfm_pkg;

  localparam int VOL_W     = 16;
  localparam int CAP_W     = 20;
  localparam int TMO_W     = 16;
  localparam int TOTAL_W   = 48;
  localparam int FLOW_W    = 28;
  localparam int IDLE_W    = 16;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;
  localparam int HOUR_W    = 12;

  localparam int INTERVAL_BITS_DEF = 32;

  // One quotient bit per cycle across the whole flow word.
  localparam int DIV_CNT_W = $clog2(FLOW_W);

  localparam logic [HOUR_W-1:0] SEC_PER_HOUR = 12'd3600;

  localparam logic [VOL_W-1:0] VOL_RST = 16'd500;
  localparam logic [CAP_W-1:0] CAP_RST = 20'd180;
  localparam logic [TMO_W-1:0] TMO_RST = 16'd10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VOLUME  = 2'd0,
    REG_CAP     = 2'd1,
    REG_TIMEOUT = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIV_IDLE = 2'd0,
    DIV_RUN  = 2'd1,
    DIV_DONE = 2'd2
  } div_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ----- design/pfm_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module pfm_div #(
  parameter int DIVISOR_W = pfm_pkg::INTERVAL_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [pfm_pkg::FLOW_W-1:0]  dividend,
  input  wire logic [DIVISOR_W-1:0]        divisor,
  output logic      [pfm_pkg::FLOW_W-1:0]  quotient,
  output pfm_pkg::div_stat_t               status
);

  import pfm_pkg::*;

  div_state_t             state_r, state_nxt;
  logic [DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [FLOW_W-1:0]      quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]   rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]   dsr_r, dsr_nxt;
  logic [DIVISOR_W:0]     trial;
  logic [DIVISOR_W:0]     diff;

  // Remainder stays below the divisor, so the shifted trial fits one extra bit.
  assign trial = {rem_r, quo_r[FLOW_W-1]};
  assign diff  = trial - {1'b0, dsr_r};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    dsr_nxt   = dsr_r;
    case (state_r)
      DIV_IDLE: begin
        if (start) begin
          quo_nxt   = dividend;
          rem_nxt   = '0;
          dsr_nxt   = divisor;
          cnt_nxt   = DIV_CNT_W'(FLOW_W - 1);
          state_nxt = DIV_RUN;
        end
      end
      DIV_RUN: begin
        if (trial >= {1'b0, dsr_r}) begin
          rem_nxt = diff[DIVISOR_W-1:0];
          quo_nxt = {quo_r[FLOW_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[DIVISOR_W-1:0];
          quo_nxt = {quo_r[FLOW_W-2:0], 1'b0};
        end
        if (cnt_r == '0) begin
          state_nxt = DIV_DONE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      DIV_DONE: begin
        state_nxt = DIV_IDLE;
      end
      default: begin
        state_nxt = DIV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DIV_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign quotient    = quo_r;
  assign status.busy = (state_r == DIV_RUN);
  assign status.done = (state_r == DIV_DONE);

endmodule

`default_nettype wire

// ----- design/pulse_flow_meter_unit.sv -----
// Pulse flow meter: a sample without a level change is answered in the cycle after acceptance.
// A level change runs a bit-serial divide, one quotient bit per cycle;
// its result is posted after the divider's run and done states; the next request waits for it.
// All other work is done in the accept cycle.
// Synchronous active-low reset clears counters, totals and flow and restores register defaults.
`timescale 1ns / 1ps
`default_nettype none

module pulse_flow_meter_unit #(
  parameter int INTERVAL_BITS = pfm_pkg::INTERVAL_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_line_level,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [pfm_pkg::TOTAL_W-1:0]    out_total_ml,
  output logic      [pfm_pkg::FLOW_W-1:0]     out_flow_milli,
  output logic                                out_pulse_seen,
  output logic                                out_decayed,
  input  wire logic                           cfg_we,
  input  wire logic [pfm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pfm_pkg::CFG_W-1:0]      cfg_wdata
);

  import pfm_pkg::*;

  logic [VOL_W-1:0]         vol_r, vol_nxt;
  logic [CAP_W-1:0]         cap_r, cap_nxt;
  logic [TMO_W-1:0]         tmo_r, tmo_nxt;

  logic                     primed_r, primed_nxt;
  logic                     last_level_r, last_level_nxt;
  logic [INTERVAL_BITS-1:0] interval_r, interval_nxt;
  logic [IDLE_W-1:0]        idle_r, idle_nxt;
  logic [TOTAL_W-1:0]       total_r, total_nxt;
  logic [FLOW_W-1:0]        flow_r, flow_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [TOTAL_W-1:0]       out_total_r, out_total_nxt;
  logic [FLOW_W-1:0]        out_flow_r, out_flow_nxt;
  logic                     out_pulse_r, out_pulse_nxt;
  logic                     out_decay_r, out_decay_nxt;

  logic                     in_acc;
  logic                     level_chg;
  logic [INTERVAL_BITS-1:0] interval_inc;
  logic [IDLE_W-1:0]        idle_inc;
  logic [TOTAL_W:0]         total_sum;
  logic [TOTAL_W-1:0]       total_add;
  logic                     timeout_hit;
  logic [FLOW_W-1:0]        flow_decay;
  logic [FLOW_W-1:0]        product;

  logic                     div_start;
  logic [FLOW_W-1:0]        div_quo;
  div_stat_t                div_st;

  pfm_div #(
    .DIVISOR_W (INTERVAL_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (product),
    .divisor  (interval_inc),
    .quotient (div_quo),
    .status   (div_st)
  );

  assign in_stall = div_st.busy || div_st.done || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;

  assign level_chg    = (in_line_level != last_level_r);
  assign interval_inc = (&interval_r) ? interval_r : interval_r + 1'b1;
  assign idle_inc     = (&idle_r) ? idle_r : idle_r + 1'b1;
  assign total_sum    = {1'b0, total_r} + (TOTAL_W + 1)'(vol_r);
  assign total_add    = total_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : total_sum[TOTAL_W-1:0];
  // A zero timeout acts like one: the compare is true on every tick.
  assign timeout_hit  = (idle_inc >= tmo_r);
  assign flow_decay   = (flow_r > FLOW_W'(cap_r)) ? FLOW_W'(cap_r) : (flow_r >> 1);
  assign product      = FLOW_W'(vol_r) * FLOW_W'(SEC_PER_HOUR);

  always_comb begin
    vol_nxt        = vol_r;
    cap_nxt        = cap_r;
    tmo_nxt        = tmo_r;
    primed_nxt     = primed_r;
    last_level_nxt = last_level_r;
    interval_nxt   = interval_r;
    idle_nxt       = idle_r;
    total_nxt      = total_r;
    flow_nxt       = flow_r;
    out_valid_nxt  = out_valid_r;
    out_total_nxt  = out_total_r;
    out_flow_nxt   = out_flow_r;
    out_pulse_nxt  = out_pulse_r;
    out_decay_nxt  = out_decay_r;
    div_start      = 1'b0;

    if (cfg_we) begin
      case (cfg_index)
        REG_VOLUME:  vol_nxt = cfg_wdata[VOL_W-1:0];
        REG_CAP:     cap_nxt = cfg_wdata[CAP_W-1:0];
        REG_TIMEOUT: tmo_nxt = cfg_wdata[TMO_W-1:0];
        default:     ;
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // Post the new flow once the divide finishes; the output slot is empty then.
    if (div_st.done) begin
      flow_nxt      = div_quo;
      out_flow_nxt  = div_quo;
      out_valid_nxt = 1'b1;
    end

    if (in_acc) begin
      if (!primed_r) begin
        primed_nxt     = 1'b1;
        last_level_nxt = in_line_level;
        out_total_nxt  = total_r;
        out_flow_nxt   = flow_r;
        out_pulse_nxt  = 1'b0;
        out_decay_nxt  = 1'b0;
        out_valid_nxt  = 1'b1;
      end else if (level_chg) begin
        last_level_nxt = in_line_level;
        total_nxt      = total_add;
        interval_nxt   = '0;
        idle_nxt       = '0;
        div_start      = 1'b1;
        out_total_nxt  = total_add;
        out_pulse_nxt  = 1'b1;
        out_decay_nxt  = 1'b0;
      end else begin
        interval_nxt  = interval_inc;
        idle_nxt      = idle_inc;
        out_decay_nxt = 1'b0;
        if (timeout_hit) begin
          idle_nxt = '0;
          if (flow_r != '0) begin
            flow_nxt      = flow_decay;
            out_decay_nxt = 1'b1;
          end
        end
        out_total_nxt = total_r;
        out_flow_nxt  = flow_nxt;
        out_pulse_nxt = 1'b0;
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vol_r        <= VOL_RST;
      cap_r        <= CAP_RST;
      tmo_r        <= TMO_RST;
      primed_r     <= 1'b0;
      last_level_r <= 1'b0;
      interval_r   <= '0;
      idle_r       <= '0;
      total_r      <= '0;
      flow_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      vol_r        <= vol_nxt;
      cap_r        <= cap_nxt;
      tmo_r        <= tmo_nxt;
      primed_r     <= primed_nxt;
      last_level_r <= last_level_nxt;
      interval_r   <= interval_nxt;
      idle_r       <= idle_nxt;
      total_r      <= total_nxt;
      flow_r       <= flow_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_total_r <= out_total_nxt;
    out_flow_r  <= out_flow_nxt;
    out_pulse_r <= out_pulse_nxt;
    out_decay_r <= out_decay_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_total_ml   = out_total_r;
  assign out_flow_milli = out_flow_r;
  assign out_pulse_seen = out_pulse_r;
  assign out_decayed    = out_decay_r;

  a_done_posts: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |=> out_valid_r)
    else $error("divide finished without posting a result");

  a_pulse_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && primed_r && level_chg) |=> div_st.busy)
    else $error("level change did not start the divider");

  a_pulse_xor_decay: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_pulse_r && out_decay_r))
    else $error("result flags both pulse and decay");

  a_decay_capped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_decay_r) |-> (out_flow_r <= FLOW_W'(cap_r)))
    else $error("decayed flow above cap");

endmodule

`default_nettype wire
